// ===== sv/gtpf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtpf_pkg
// Shared types, constants and helpers for the grayscale tint pixel filter.
// ----------------------------------------------------------------------------
package gtpf_pkg;

    localparam int CHAN_W   = 8;
    localparam int PIXEL_W  = 3 * CHAN_W;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 8;

    localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;
    localparam logic [CHAN_W-1:0] LIFT_BASE  = 8'd179;
    localparam logic [CHAN_W-1:0] LIFT_SPAN  = FULL_SCALE - LIFT_BASE;

    localparam logic [CHAN_W-1:0] LUMA_KR = 8'd77;
    localparam logic [CHAN_W-1:0] LUMA_KG = 8'd150;
    localparam logic [CHAN_W-1:0] LUMA_KB = 8'd29;
    localparam logic [15:0]       LUMA_RND = 16'd128;

    typedef enum logic [1:0] {
        MODE_PASS  = 2'd0,
        MODE_SCALE = 2'd1,
        MODE_BLEND = 2'd2,
        MODE_LIFT  = 2'd3
    } tint_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TINT_RED   = 8'd0,
        REG_TINT_GREEN = 8'd1,
        REG_TINT_BLUE  = 8'd2,
        REG_TINT_MODE  = 8'd3
    } cfg_reg_t;

    // Exact x/255 for x up to 255*255.
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

endpackage

// ===== sv/grayscale_tint_pixel_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grayscale_tint_pixel_filter
// Throughput: one pixel per cycle unless the output stalls; four register
// stages (luma, gain select, channel multiply, divide and output) advance
// under a ready chain. In pass mode words go through unchanged.
// Reset (rst_n low, async): pipeline emptied, tint color and mode cleared.
// Converts each RGB24 word to BT.601 gray and tints it with the set color.
// ----------------------------------------------------------------------------
module grayscale_tint_pixel_filter
    import gtpf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [PIXEL_W-1:0]   s_axis_tdata,  // pixel_red, pixel_green, pixel_blue
    input  logic                 s_axis_tlast,  // frame_end
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [PIXEL_W-1:0]   m_axis_tdata,  // out_red, out_green, out_blue
    output logic                 m_axis_tlast,  // out_frame_end
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    logic [CHAN_W-1:0] tint_reg [3];
    tint_mode_t        mode_reg;

    // stage valids and readies
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready;

    logic [PIXEL_W-1:0] s1_pix_reg, s2_pix_reg, s3_pix_reg, s4_pix_reg;
    logic               s1_last_reg, s2_last_reg, s3_last_reg, s4_last_reg;
    logic [CHAN_W-1:0]  s1_gray_reg;
    logic [CHAN_W-1:0]  s2_gain_reg, s2_base_reg, s3_base_reg;
    logic [15:0]        s3_prod_reg [3];

    logic [CHAN_W-1:0]  gray_next, gain_next, base_next;
    logic [15:0]        luma_sum;
    logic [15:0]        lift_prod;
    logic [PIXEL_W-1:0] out_next;

    assign s4_ready = !s4_valid_reg || m_axis_tready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;

    assign s_axis_tready = s1_ready;
    assign cfg_ready     = 1'b1;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tint_reg[0] <= '0;
            tint_reg[1] <= '0;
            tint_reg[2] <= '0;
            mode_reg    <= MODE_PASS;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TINT_RED:   tint_reg[0] <= cfg_data;
                REG_TINT_GREEN: tint_reg[1] <= cfg_data;
                REG_TINT_BLUE:  tint_reg[2] <= cfg_data;
                REG_TINT_MODE:  mode_reg    <= tint_mode_t'(cfg_data[1:0]);
                default:        ;
            endcase
        end
    end

    // stage 1: luma
    always_comb
    begin
        luma_sum = 16'(s_axis_tdata[7:0] * LUMA_KR)
                 + 16'(s_axis_tdata[15:8] * LUMA_KG)
                 + 16'(s_axis_tdata[23:16] * LUMA_KB)
                 + LUMA_RND;
        gray_next = luma_sum[15:8];
    end

    // stage 2: gain and offset; blend is gray + c*(255-gray)/255
    always_comb
    begin
        lift_prod = 16'(s1_gray_reg * LIFT_SPAN);
        gain_next = s1_gray_reg;
        base_next = '0;
        case (mode_reg)
            MODE_BLEND:
            begin
                gain_next = FULL_SCALE - s1_gray_reg;
                base_next = s1_gray_reg;
            end
            MODE_LIFT:  gain_next = LIFT_BASE + div255(lift_prod);
            default:    gain_next = s1_gray_reg;
        endcase
    end

    // stage 4: divide and select
    always_comb
    begin
        if (mode_reg == MODE_PASS)
            out_next = s3_pix_reg;
        else
            out_next = {s3_base_reg + div255(s3_prod_reg[2]),
                        s3_base_reg + div255(s3_prod_reg[1]),
                        s3_base_reg + div255(s3_prod_reg[0])};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= s_axis_tvalid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
            if (s4_ready)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_pix_reg  <= s_axis_tdata;
            s1_last_reg <= s_axis_tlast;
            s1_gray_reg <= gray_next;
        end
        if (s2_ready)
        begin
            s2_pix_reg  <= s1_pix_reg;
            s2_last_reg <= s1_last_reg;
            s2_gain_reg <= gain_next;
            s2_base_reg <= base_next;
        end
        if (s3_ready)
        begin
            s3_pix_reg     <= s2_pix_reg;
            s3_last_reg    <= s2_last_reg;
            s3_base_reg    <= s2_base_reg;
            s3_prod_reg[0] <= 16'(tint_reg[0] * s2_gain_reg);
            s3_prod_reg[1] <= 16'(tint_reg[1] * s2_gain_reg);
            s3_prod_reg[2] <= 16'(tint_reg[2] * s2_gain_reg);
        end
        if (s4_ready)
        begin
            s4_pix_reg  <= out_next;
            s4_last_reg <= s3_last_reg;
        end
    end

    assign m_axis_tvalid = s4_valid_reg;
    assign m_axis_tdata  = s4_pix_reg;
    assign m_axis_tlast  = s4_last_reg;

endmodule

// ===== sv/gtpf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtpf_checker
// Port-level checks for the grayscale tint pixel filter, bound to the top.
// ----------------------------------------------------------------------------
module gtpf_checker
    import gtpf_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 s_axis_tlast,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [PIXEL_W-1:0]   m_axis_tdata,
    input logic                 m_axis_tlast
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed under stall");

    // empty output register means input side is open
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // word accepted while the output stays ready arrives with its frame marker
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
            ##1 m_axis_tready |=>
            m_axis_tvalid && (m_axis_tlast == $past(s_axis_tlast, 4)))
        else $error("word missing or marker mismatch at latency");

endmodule

bind grayscale_tint_pixel_filter gtpf_checker u_gtpf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== bench/grayscale_tint_pixel_filter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grayscale_tint_pixel_filter_tb
// Streams RGB24 pixels through the tint filter and checks every output word
// against a local tint calculation. The run has a short directed part and then
// random phases. Each phase writes a new tint color and mode while the pipe is
// empty. Both stream sides idle at random. Once, the output side holds off long
// enough for the block to fill up and stall its input.
// ----------------------------------------------------------------------------
module grayscale_tint_pixel_filter_tb;
    import gtpf_pkg::*;

    localparam int CYCLE_LIMIT  = 800000;
    localparam int PIXEL_TARGET = 1750;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

    typedef struct packed {
        logic              last;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_t;

    typedef struct {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        tint_mode_t        mode;
    } tint_cfg_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [PIXEL_W-1:0]   s_axis_tdata = '0;   // pixel_red, pixel_green, pixel_blue
    logic                 s_axis_tlast = 1'b0; // frame_end
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [PIXEL_W-1:0]   m_axis_tdata;        // out_red, out_green, out_blue
    logic                 m_axis_tlast;        // out_frame_end
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    pixel_t    pending_pixels[$];
    pixel_t    tinted_words[$];
    tint_cfg_t tint_cfg;

    int  send_gap = 0;
    int  recv_stall = 0;
    bit  calm = 1'b0;
    bit  hold_off = 1'b0;
    int  pixels_in = 0;
    int  frames_in = 0;
    int  words_out = 0;
    int  reg_writes = 0;
    int  phases = 0;
    int  pixels_queued = 0;
    int  errors = 0;
    int  cycles = 0;
    pixel_t sent_px;
    pixel_t next_px;
    pixel_t want_px;

    grayscale_tint_pixel_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [CHAN_W-1:0] tint_channel(logic [CHAN_W-1:0] c,
                                                       int unsigned gray,
                                                       tint_mode_t mode);
        int unsigned cc;
        int unsigned full;
        int unsigned lifted;
        int unsigned v;
        cc   = c;
        full = FULL_SCALE;
        case (mode)
            MODE_SCALE: v = cc * gray / full;
            MODE_BLEND: v = (cc * (full - gray) + full * gray) / full;
            MODE_LIFT:
            begin
                lifted = int'(LIFT_BASE) + gray * int'(LIFT_SPAN) / full;
                v = cc * lifted / full;
            end
            default:    v = cc;
        endcase
        return v[CHAN_W-1:0];
    endfunction

    function automatic pixel_t tint_pixel(pixel_t px, tint_cfg_t c);
        int unsigned gray;
        pixel_t      o;
        gray = (int'(LUMA_KR) * px.red + int'(LUMA_KG) * px.green
                + int'(LUMA_KB) * px.blue + int'(LUMA_RND)) >> 8;
        o.last = px.last;
        if (c.mode == MODE_PASS)
        begin
            o.red   = px.red;
            o.green = px.green;
            o.blue  = px.blue;
        end
        else
        begin
            o.red   = tint_channel(c.red, gray, c.mode);
            o.green = tint_channel(c.green, gray, c.mode);
            o.blue  = tint_channel(c.blue, gray, c.mode);
        end
        return o;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 55)
            return 0;
        else if (r < 85)
            return int'($urandom_range(1, 3));
        else if (r < 97)
            return int'($urandom_range(4, 10));
        return int'($urandom_range(20, 60));
    endfunction

    function automatic logic [CHAN_W-1:0] rand_chan();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return CHAN_W'($urandom_range(0, 255));
    endfunction

    task automatic report(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    task automatic push_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                              logic [CHAN_W-1:0] b, logic last);
        pixel_t px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        px.last  = last;
        pending_pixels.push_back(px);
        pixels_queued++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_TINT_RED:   tint_cfg.red   = val;
            REG_TINT_GREEN: tint_cfg.green = val;
            REG_TINT_BLUE:  tint_cfg.blue  = val;
            REG_TINT_MODE:  tint_cfg.mode  = tint_mode_t'(val[1:0]);
            default: ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_tint(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                              logic [CHAN_W-1:0] b, tint_mode_t m, logic [5:0] junk);
        write_reg(REG_TINT_RED, r);
        write_reg(REG_TINT_GREEN, g);
        write_reg(REG_TINT_BLUE, b);
        write_reg(REG_TINT_MODE, {junk, m});
        phases++;
    endtask

    // sampled away from the rising edge so the driver's updates have settled
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_pixels.size() != 0 || s_axis_tvalid || tinted_words.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // pixel driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            send_gap      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                sent_px.red   = s_axis_tdata[CHAN_W-1:0];
                sent_px.green = s_axis_tdata[2*CHAN_W-1:CHAN_W];
                sent_px.blue  = s_axis_tdata[3*CHAN_W-1:2*CHAN_W];
                sent_px.last  = s_axis_tlast;
                tinted_words.push_back(tint_pixel(sent_px, tint_cfg));
                pixels_in <= pixels_in + 1;
                if (s_axis_tlast)
                    frames_in <= frames_in + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap      <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_pixels.size() != 0)
                begin
                    next_px = pending_pixels.pop_front();
                    s_axis_tdata  <= {next_px.blue, next_px.green, next_px.red};
                    s_axis_tlast  <= next_px.last;
                    s_axis_tvalid <= 1'b1;
                    send_gap      <= calm ? 0 : pick_gap();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output monitor and ready pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_stall    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                words_out <= words_out + 1;
                if (tinted_words.size() == 0)
                    report($sformatf("output word %h/%b with no pixel pending",
                                     m_axis_tdata, m_axis_tlast));
                else
                begin
                    want_px = tinted_words.pop_front();
                    if (m_axis_tdata[CHAN_W-1:0] !== want_px.red)
                        report($sformatf("word %0d red: want %0d got %0d", words_out,
                                         want_px.red, m_axis_tdata[CHAN_W-1:0]));
                    if (m_axis_tdata[2*CHAN_W-1:CHAN_W] !== want_px.green)
                        report($sformatf("word %0d green: want %0d got %0d", words_out,
                                         want_px.green, m_axis_tdata[2*CHAN_W-1:CHAN_W]));
                    if (m_axis_tdata[3*CHAN_W-1:2*CHAN_W] !== want_px.blue)
                        report($sformatf("word %0d blue: want %0d got %0d", words_out,
                                         want_px.blue, m_axis_tdata[3*CHAN_W-1:2*CHAN_W]));
                    if (m_axis_tlast !== want_px.last)
                        report($sformatf("word %0d frame end: want %b got %b", words_out,
                                         want_px.last, m_axis_tlast));
                end
            end
            if (hold_off)
                m_axis_tready <= 1'b0;
            else if (recv_stall != 0)
            begin
                recv_stall    <= recv_stall - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    recv_stall <= pick_gap();
            end
        end
    end

    // long output back-pressure while the input side keeps offering
    initial
    begin
        wait (pixels_in >= 300 && pending_pixels.size() >= 100);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words pending", cycles,
                     tinted_words.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        tint_cfg.red   = '0;
        tint_cfg.green = '0;
        tint_cfg.blue  = '0;
        tint_cfg.mode  = MODE_PASS;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset values: pass-through
        @(negedge clk);
        push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        push_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
        push_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
        push_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
        push_pixel(8'h55, 8'hAA, 8'h55, 1'b1);
        wait_drained();

        // writes to unused indexes must not land anywhere
        write_reg(REG_UNUSED_LO, 8'hFF);
        write_reg(REG_UNUSED_HI, 8'hFF);
        apply_tint(8'hFF, 8'hFF, 8'hFF, MODE_SCALE, 6'd0);
        @(negedge clk);
        push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
        push_pixel(8'h80, 8'h80, 8'h80, 1'b1);
        wait_drained();

        apply_tint(8'h00, 8'h80, 8'hFF, MODE_BLEND, 6'd0);
        @(negedge clk);
        push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        push_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
        push_pixel(8'h00, 8'h00, 8'hFF, 1'b1);
        wait_drained();

        apply_tint(8'hFF, 8'h01, 8'h00, MODE_LIFT, 6'd0);
        @(negedge clk);
        push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
        push_pixel(8'h7F, 8'h7F, 8'h7F, 1'b1);
        wait_drained();

        // mode written with upper bits set: only the low two count
        apply_tint(8'h01, 8'hFE, 8'h80, MODE_SCALE, 6'h3F);
        write_reg(REG_UNUSED_LO, 8'h02);
        @(negedge clk);
        push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        push_pixel(8'h12, 8'h34, 8'h56, 1'b0);
        push_pixel(8'hFE, 8'hFE, 8'hFE, 1'b1);
        wait_drained();

        while (pixels_queued < PIXEL_TARGET)
        begin
            case ($urandom_range(0, 3))
                0: apply_tint(8'h00, 8'h00, 8'h00, tint_mode_t'($urandom_range(0, 3)),
                              6'($urandom_range(0, 63)));
                1: apply_tint(8'hFF, 8'hFF, 8'hFF, tint_mode_t'($urandom_range(0, 3)),
                              6'($urandom_range(0, 63)));
                default: apply_tint(rand_chan(), rand_chan(), rand_chan(),
                                    tint_mode_t'($urandom_range(0, 3)),
                                    6'($urandom_range(0, 63)));
            endcase
            if ($urandom_range(0, 4) == 0)
                write_reg(CFG_IDX_W'($urandom_range(int'(REG_UNUSED_LO), 255)),
                          CFG_DAT_W'($urandom_range(0, 255)));
            @(negedge clk);
            calm = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(150, 250))
                push_pixel(rand_chan(), rand_chan(), rand_chan(), $urandom_range(0, 15) == 0);
            wait_drained();
            @(negedge clk);
            calm = 1'b0;
        end

        wait_drained();
        repeat (4 * DRAIN_CYCLES) @(posedge clk);
        if (tinted_words.size() != 0)
            report($sformatf("%0d tinted words never came out", tinted_words.size()));

        $display("ran %0d pixels in %0d frames through %0d tint settings", pixels_in,
                 frames_in, phases);
        $display("%0d register writes, %0d output words, %0d mismatches", reg_writes,
                 words_out, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
